/* rtl/core/qidt_pkg.sv */
// Package: commands, sequencer states and constants for the query ID translation table.
package qidt_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_TAKE   = 2'd1,
		CMD_EXPIRE = 2'd2,
		CMD_NEXT   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_CHECK,
		ST_ALLOC,
		ST_DONE
	} state_t;

	localparam logic [0:0] REG_TIMEOUT = 1'b0;
	localparam logic [0:0] REG_IDLE    = 1'b1;

	localparam logic [15:0] ID_MAX = 16'hFFFF;
	localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
	localparam logic [31:0] IDLE_RESET = 32'd1000;

endpackage

/* rtl/core/query_id_translation_table.sv */
// Top level: query ID translation table with a sequenced slot scan.
//
// A command is taken when start is high and busy is low; busy then stays high
// while a sequencer walks the slot memory one entry per cycle. Each command
// yields exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. take, expire and next each scan all CAPACITY slots, and the
// next command can be taken in the same cycle as the result beat. insert scans
// once to find a free slot and then, if one was found and the table is not
// full, tests each candidate ID against the table with a full scan, one pass
// per cursor value checked (one unless IDs near the cursor are held). The scan
// length is set by the single read port of the slot memory, shared by every
// command.
// No clearing pass is needed: valid bits live in flip-flops cleared by reset.
// Configuration writes go through cfg_valid/cfg_ready; write only while busy
// is low and no command is being started, so a command sees one set of values.
module query_id_translation_table
	import qidt_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [47:0] now_ms,
	input  logic [15:0] client_query_id,
	input  logic [63:0] client_tag,
	input  logic [7:0]  client_tag_len,
	input  logic [15:0] lookup_id,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic        ok,
	output logic [15:0] assigned_id,
	output logic [15:0] found_query_id,
	output logic [63:0] found_tag,
	output logic [7:0]  found_tag_len,
	output logic [6:0]  removed_count,
	output logic [31:0] remain_ms,
	output logic [6:0]  pending_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// configuration
	logic [31:0] timeout_q, idle_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			idle_q <= IDLE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_IDLE: idle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot memory (payload) and valid bits
	logic [15:0] mem_uid [CAPACITY];
	logic [15:0] mem_cid [CAPACITY];
	logic [63:0] mem_tag [CAPACITY];
	logic [7:0]  mem_len [CAPACITY];
	logic [47:0] mem_dl  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;

	// latched command
	cmd_t        cmd_q;
	logic [47:0] now_q;
	logic [15:0] cid_q, want_q;
	logic [63:0] tag_q;
	logic [7:0]  len_q;

	state_t state_q, state_d;
	logic [AW-1:0] addr_q;   // address being read this cycle
	logic          rd_v_q;   // read data valid this cycle
	logic [AW-1:0] rd_a_q;   // address of read data
	logic          last_q;   // read was the last address
	logic [15:0] rd_uid_q, rd_cid_q;
	logic [63:0] rd_tag_q;
	logic [7:0]  rd_len_q;
	logic [47:0] rd_dl_q;

	logic [CW-1:0] held_q;
	logic [15:0]   cursor_q, cand_q;
	logic          hit_q;     // candidate ID held / take found
	logic          free_f_q;  // free slot found
	logic [AW-1:0] free_a_q;
	logic [6:0]    removed_q;
	logic [47:0]   best_q;
	logic          due_q;
	logic          ok_q;

	// payload of the taken entry
	logic [15:0] take_cid_q;
	logic [63:0] take_tag_q;
	logic [7:0]  take_len_q;

	// memory read port
	always_ff @(posedge clk) begin
		rd_uid_q <= mem_uid[addr_q];
		rd_cid_q <= mem_cid[addr_q];
		rd_tag_q <= mem_tag[addr_q];
		rd_len_q <= mem_len[addr_q];
		rd_dl_q  <= mem_dl[addr_q];
	end

	// shared compare unit on the registered read beat
	logic        rv;
	logic        id_eq, is_due;
	logic [47:0] diff;
	logic [15:0] key;
	logic        hit_now;
	assign rv = rd_v_q && valid_q[rd_a_q];
	assign key = (cmd_q == CMD_INSERT) ? cand_q : want_q;
	assign id_eq = rd_uid_q == key;
	assign is_due = rd_dl_q <= now_q;
	assign diff = rd_dl_q - now_q;
	// candidate ID seen in any valid slot so far in this pass
	assign hit_now = hit_q || (rv && id_eq);

	logic [48:0] dl_sum;
	logic [47:0] dl_new;
	assign dl_sum = {1'b0, now_q} + {17'd0, timeout_q};
	assign dl_new = dl_sum[48] ? DEADLINE_MAX : dl_sum[47:0];

	logic addr_last;
	assign addr_last = addr_q == AW'(CAPACITY - 1);

	logic can_insert;
	assign can_insert = free_f_q && held_q != CW'(CAPACITY);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (addr_last) state_d = ST_WAIT;
			ST_WAIT: state_d = (cmd_q == CMD_INSERT) ? ST_CHECK : ST_DONE;
			ST_CHECK: begin
				// first pass looked for a free slot; candidate passes follow if one was found and the table is not full
				if (!can_insert) state_d = ST_DONE;
				else state_d = ST_ALLOC;
			end
			ST_ALLOC: begin
				// stay for another pass while the candidate is held
				if (rd_v_q && last_q && !hit_now) state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_t'(cmd);
			now_q <= now_ms;
			cid_q <= client_query_id;
			tag_q <= client_tag;
			len_q <= client_tag_len;
			want_q <= lookup_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			held_q <= '0;
			cursor_q <= 16'd1;
			addr_q <= '0;
			rd_v_q <= 1'b0;
			rd_a_q <= '0;
			last_q <= 1'b0;
			done <= 1'b0;
			hit_q <= 1'b0;
			free_f_q <= 1'b0;
			free_a_q <= '0;
			removed_q <= '0;
			best_q <= '0;
			due_q <= 1'b0;
			ok_q <= 1'b0;
			cand_q <= '0;
		end else begin
			done <= 1'b0;
			rd_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					hit_q <= 1'b0;
					free_f_q <= 1'b0;
					removed_q <= '0;
					best_q <= {16'd0, idle_q};
					due_q <= 1'b0;
					ok_q <= 1'b0;
				end
				ST_SCAN, ST_WAIT: begin
					if (state_q == ST_SCAN) begin
						rd_v_q <= 1'b1;
						rd_a_q <= addr_q;
						last_q <= addr_last;
						addr_q <= addr_last ? '0 : addr_q + AW'(1);
					end
					if (rd_v_q) begin
						case (cmd_q)
							CMD_INSERT: begin
								if (!valid_q[rd_a_q] && !free_f_q) begin
									free_f_q <= 1'b1;
									free_a_q <= rd_a_q;
								end
							end
							CMD_TAKE: begin
								if (rv && id_eq && !hit_q) begin
									hit_q <= 1'b1;
									valid_q[rd_a_q] <= 1'b0;
									held_q <= held_q - CW'(1);
								end
							end
							CMD_EXPIRE: begin
								if (rv && is_due) begin
									valid_q[rd_a_q] <= 1'b0;
									held_q <= held_q - CW'(1);
									removed_q <= removed_q + 7'd1;
								end
							end
							CMD_NEXT: begin
								if (rv) begin
									if (is_due) due_q <= 1'b1;
									else if (diff < best_q) best_q <= diff;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					// take the cursor value as candidate and advance the cursor
					if (can_insert) begin
						cand_q <= cursor_q;
						cursor_q <= (cursor_q == ID_MAX) ? 16'd1 : cursor_q + 16'd1;
					end
					hit_q <= 1'b0;
					addr_q <= '0;
				end
				ST_ALLOC: begin
					if (!rd_v_q || !last_q) begin
						rd_v_q <= 1'b1;
						rd_a_q <= addr_q;
						last_q <= addr_last;
						addr_q <= addr_last ? '0 : addr_q + AW'(1);
					end
					if (rd_v_q) begin
						if (!last_q) begin
							hit_q <= hit_now;
						end else if (hit_now) begin
							// candidate held: try the next cursor value
							rd_v_q <= 1'b0;
							hit_q <= 1'b0;
							addr_q <= '0;
							cand_q <= cursor_q;
							cursor_q <= (cursor_q == ID_MAX) ? 16'd1 : cursor_q + 16'd1;
						end else begin
							rd_v_q <= 1'b0;
							ok_q <= 1'b1;
							valid_q[free_a_q] <= 1'b1;
							held_q <= held_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					done <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// memory write port: insert commits into the free slot
	always_ff @(posedge clk) begin
		if (state_q == ST_ALLOC && rd_v_q && last_q && !hit_now) begin
			mem_uid[free_a_q] <= cand_q;
			mem_cid[free_a_q] <= cid_q;
			mem_tag[free_a_q] <= tag_q;
			mem_len[free_a_q] <= len_q;
			mem_dl[free_a_q]  <= dl_new;
		end
	end

	// result beat
	always_comb begin
		ok = 1'b0;
		assigned_id = '0;
		found_query_id = '0;
		found_tag = '0;
		found_tag_len = '0;
		removed_count = '0;
		remain_ms = '0;
		pending_count = 7'(held_q);
		case (cmd_q)
			CMD_INSERT: begin
				ok = ok_q;
				assigned_id = ok_q ? cand_q : 16'd0;
			end
			CMD_TAKE: begin
				ok = hit_q;
				if (hit_q) begin
					found_query_id = take_cid_q;
					found_tag = take_tag_q;
					found_tag_len = take_len_q;
				end
			end
			CMD_EXPIRE: removed_count = removed_q;
			CMD_NEXT: remain_ms = due_q ? 32'd0 : best_q[31:0];
			default: ;
		endcase
	end

	// hold the payload of the taken entry
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN || state_q == ST_WAIT) && rd_v_q && cmd_q == CMD_TAKE
			&& rv && id_eq && !hit_q) begin
			take_cid_q <= rd_cid_q;
			take_tag_q <= rd_tag_q;
			take_len_q <= rd_len_q;
		end
	end

	// the held count never exceeds the table size
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY)) else $error("held count above capacity");
	// a result beat comes only at the end of a command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	// a successful insert never issues ID zero
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok && cmd_q == CMD_INSERT) |-> assigned_id != 16'd0)
		else $error("zero ID issued");
	// the cursor never holds zero
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != 16'd0) else $error("cursor zero");

endmodule

/* bench/relay_table_checker.sv */
// Checker for the query ID translation table: predicts each reply and compares it.
module relay_table_checker
	import qidt_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [47:0] now_ms,
	input  logic [15:0] client_query_id,
	input  logic [63:0] client_tag,
	input  logic [7:0]  client_tag_len,
	input  logic [15:0] lookup_id,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic        ok,
	input  logic [15:0] assigned_id,
	input  logic [15:0] found_query_id,
	input  logic [63:0] found_tag,
	input  logic [7:0]  found_tag_len,
	input  logic [6:0]  removed_count,
	input  logic [31:0] remain_ms,
	input  logic [6:0]  pending_count,
	output int          mismatches,
	output int          awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bit        ok;
		bit [15:0] assigned_id;
		bit [15:0] query_id;
		bit [63:0] tag;
		bit [7:0]  tag_len;
		bit [6:0]  removed;
		bit [31:0] remain;
		bit [6:0]  pending;
	} reply_t;

	bit [31:0] lifetime;
	bit [31:0] idle_cap;
	bit        live[CAPACITY];
	bit [15:0] up_id[CAPACITY];
	bit [15:0] cl_id[CAPACITY];
	bit [63:0] cl_tag[CAPACITY];
	bit [7:0]  cl_len[CAPACITY];
	bit [47:0] deadline[CAPACITY];
	bit [15:0] cursor;
	int        held;
	reply_t    expected_replies[$];

	function automatic bit upstream_id_live(bit [15:0] id);
		for (int i = 0; i < CAPACITY; i++)
			if (live[i] && up_id[i] == id)
				return 1;
		return 0;
	endfunction

	function automatic reply_t predict_reply(cmd_t c, bit [47:0] now, bit [15:0] qid,
			bit [63:0] tag, bit [7:0] len, bit [15:0] want);
		reply_t r;
		bit [15:0] id;
		bit [15:0] cand;
		bit [48:0] dl;
		longint unsigned best;
		int slot;
		r = '0;
		case (c)
			CMD_INSERT: begin
				if (held < CAPACITY) begin
					id = 0;
					for (int t = 0; t < 65535; t++) begin
						cand = cursor;
						cursor = (cursor == ID_MAX) ? 16'd1 : cursor + 16'd1;
						if (!upstream_id_live(cand)) begin
							id = cand;
							break;
						end
					end
					slot = -1;
					for (int i = 0; i < CAPACITY; i++)
						if (!live[i]) begin
							slot = i;
							break;
						end
					if (id != 0 && slot >= 0) begin
						dl = {1'b0, now} + {17'd0, lifetime};
						if (dl > {1'b0, DEADLINE_MAX})
							dl = {1'b0, DEADLINE_MAX};
						live[slot] = 1;
						up_id[slot] = id;
						cl_id[slot] = qid;
						cl_tag[slot] = tag;
						cl_len[slot] = len;
						deadline[slot] = dl[47:0];
						held++;
						r.ok = 1;
						r.assigned_id = id;
					end
				end
			end
			CMD_TAKE: begin
				for (int i = 0; i < CAPACITY; i++)
					if (live[i] && up_id[i] == want) begin
						live[i] = 0;
						held--;
						r.ok = 1;
						r.query_id = cl_id[i];
						r.tag = cl_tag[i];
						r.tag_len = cl_len[i];
						break;
					end
			end
			CMD_EXPIRE: begin
				for (int i = 0; i < CAPACITY; i++)
					if (live[i] && deadline[i] <= now) begin
						live[i] = 0;
						held--;
						r.removed++;
					end
			end
			default: begin
				best = idle_cap;
				for (int i = 0; i < CAPACITY; i++)
					if (live[i]) begin
						if (deadline[i] <= now) begin
							best = 0;
							break;
						end
						if (longint'(deadline[i] - now) < best)
							best = deadline[i] - now;
					end
				r.remain = best[31:0];
			end
		endcase
		r.pending = held[6:0];
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	assign awaited = expected_replies.size();

	always @(posedge clk or negedge arst_n) begin
		reply_t w;
		if (!arst_n) begin
			lifetime = TIMEOUT_RESET;
			idle_cap = IDLE_RESET;
			for (int i = 0; i < CAPACITY; i++)
				live[i] = 0;
			cursor = 1;
			held = 0;
			expected_replies.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (expected_replies.size() == 0) begin
					report("reply with nothing pending", 0, 0);
				end else begin
					w = expected_replies.pop_front();
					if (ok !== w.ok) report("ok", ok, w.ok);
					if (assigned_id !== w.assigned_id)
						report("assigned_id", assigned_id, w.assigned_id);
					if (found_query_id !== w.query_id)
						report("found_query_id", found_query_id, w.query_id);
					if (found_tag !== w.tag) report("found_tag", found_tag, w.tag);
					if (found_tag_len !== w.tag_len)
						report("found_tag_len", found_tag_len, w.tag_len);
					if (removed_count !== w.removed)
						report("removed_count", removed_count, w.removed);
					if (remain_ms !== w.remain) report("remain_ms", remain_ms, w.remain);
					if (pending_count !== w.pending)
						report("pending_count", pending_count, w.pending);
				end
			end
			if (start && !busy)
				expected_replies.push_back(predict_reply(cmd_t'(cmd), now_ms,
					client_query_id, client_tag, client_tag_len, lookup_id));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TIMEOUT)
					lifetime = cfg_data;
				else
					idle_cap = cfg_data;
			end
		end
	end
endmodule

/* bench/testbench.sv */
// Top of the bench: drives commands and register writes and gives the verdict.
module testbench;
	import qidt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  cmd = CMD_NEXT;
	logic [47:0] now_ms = 0;
	logic [15:0] client_query_id = 0;
	logic [63:0] client_tag = 0;
	logic [7:0]  client_tag_len = 0;
	logic [15:0] lookup_id = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = REG_TIMEOUT;
	logic [31:0] cfg_data = 0;
	logic        done, ok;
	logic [15:0] assigned_id, found_query_id;
	logic [63:0] found_tag;
	logic [7:0]  found_tag_len;
	logic [6:0]  removed_count, pending_count;
	logic [31:0] remain_ms;
	int          mismatches, awaited;

	// The last 200 upstream IDs handed out; most takes draw from here, stale ones included.
	logic [15:0] issued_ids[$];
	int          burst_left = 0;
	logic [47:0] clock_ms;

	always #5 clk = ~clk;

	query_id_translation_table dut (.*);

	relay_table_checker checker_i (.*);

	// Collect every ID the block reports for a successful insert.
	always @(posedge clk) begin
		if (done && ok && assigned_id != 0) begin
			issued_ids.push_back(assigned_id);
			if (issued_ids.size() > 200)
				void'(issued_ids.pop_front());
		end
	end

	// Present one command and hold it until the block takes the beat; then
	// either keep start high for the next beat or drop it for a random gap.
	task automatic issue(cmd_t c, logic [47:0] now, logic [15:0] qid, logic [63:0] tag,
			logic [7:0] len, logic [15:0] want);
		cmd <= c;
		now_ms <= now;
		client_query_id <= qid;
		client_tag <= tag;
		client_tag_len <= len;
		lookup_id <= want;
		start <= 1;
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 5);
			if ($urandom_range(0, 2) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 80)) @(posedge clk);
			end
		end
	endtask

	// Drop start and hold until every reply has come back.
	task automatic drain;
		start <= 0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Random command with random content; ins_weight sets how often it inserts.
	task automatic random_command(int ins_weight);
		int pick;
		logic [15:0] want;
		pick = $urandom_range(0, 99);
		// advance time mostly in small steps, now and then with a long jump
		if ($urandom_range(0, 19) == 0)
			clock_ms = clock_ms + 48'({$urandom, $urandom} % 48'h10_0000_0000);
		else
			clock_ms = clock_ms + $urandom_range(0, 1500);
		if (pick < ins_weight) begin
			issue(CMD_INSERT, clock_ms, 16'($urandom), {$urandom, $urandom}, 8'($urandom),
				16'($urandom));
		end else if (pick < ins_weight + (100 - ins_weight) * 2 / 5) begin
			case ($urandom_range(0, 4))
				0: want = 0;
				1: want = 16'($urandom);
				default: want = issued_ids.size() ? issued_ids[$urandom_range(0,
					issued_ids.size() - 1)] : 16'd1;
			endcase
			issue(CMD_TAKE, clock_ms, 16'($urandom), {$urandom, $urandom}, 8'($urandom),
				want);
		end else if (pick < ins_weight + (100 - ins_weight) * 7 / 10) begin
			issue(CMD_EXPIRE, clock_ms, 16'($urandom), {$urandom, $urandom}, 8'($urandom),
				16'($urandom));
		end else begin
			issue(CMD_NEXT, clock_ms, 16'($urandom), {$urandom, $urandom}, 8'($urandom),
				16'($urandom));
		end
	endtask

	initial begin
		logic [31:0] lifetimes[7];
		logic [31:0] caps[7];
		int          weights[7];
		logic [47:0] bases[7];
		lifetimes = '{32'd3000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd20000, 32'hFFFF_FFFF, 32'd800};
		caps      = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd50, 32'hFFFF_FFFF, 32'd0, 32'd2000};
		weights   = '{40, 40, 85, 35, 50, 60, 30};
		bases     = '{48'd10000, 48'd0, 48'd100000, 48'd5, 48'h7FFF_0000_0000,
			48'hFFFF_FFFF_0000, 48'd300};

		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed part, with reset register values (5000 ms lifetime, 1000 ms cap).
		issue(CMD_NEXT, 0, 0, 0, 0, 0);                       // empty table answers the cap
		issue(CMD_EXPIRE, 0, 0, 0, 0, 0);
		issue(CMD_TAKE, 0, 0, 0, 0, 16'd0);                   // zero ID never matches
		issue(CMD_INSERT, 0, 16'h0000, 64'h0, 8'h00, 0);      // gets ID 1
		issue(CMD_INSERT, 0, 16'hFFFF, '1, 8'hFF, '1);        // gets ID 2
		issue(CMD_INSERT, 100, 16'h1234, 64'h0123_4567_89AB_CDEF, 8'd128, 0);
		issue(CMD_TAKE, 100, 0, 0, 0, 16'd2);                 // found
		issue(CMD_TAKE, 100, 0, 0, 0, 16'd2);                 // already gone
		issue(CMD_TAKE, 100, 0, 0, 0, 16'hFFFF);              // unknown
		issue(CMD_NEXT, 4500, 0, 0, 0, 0);
		issue(CMD_NEXT, 5000, 0, 0, 0, 0);                    // due at exactly now
		issue(CMD_EXPIRE, 4999, 0, 0, 0, 0);                  // one short of the deadline
		issue(CMD_EXPIRE, 5000, 0, 0, 0, 0);                  // deadline equals now
		issue(CMD_NEXT, 5000, 0, 0, 0, 0);
		issue(CMD_INSERT, DEADLINE_MAX - 1, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 0);
		issue(CMD_EXPIRE, 5100, 0, 0, 0, 0);
		issue(CMD_NEXT, 5100, 0, 0, 0, 0);                    // saturated deadline, capped
		issue(CMD_EXPIRE, DEADLINE_MAX, 0, 0, 0, 0);          // clear the saturated entry

		// Random phases, each under its own register settings; the sender
		// pauses until the table is quiet before every write.
		for (int p = 0; p < 7; p++) begin
			drain();
			write_reg(REG_TIMEOUT, lifetimes[p]);
			write_reg(REG_IDLE, caps[p]);
			clock_ms = bases[p];
			for (int n = 0; n < 140; n++)
				random_command(weights[p]);
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#300_000_000;
		$display("status: fail");
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/qidt_pkg.sv
rtl/core/query_id_translation_table.sv
bench/relay_table_checker.sv
bench/testbench.sv
